// File: sv/imucal_pkg.sv
// imucal_pkg: types and constants for the six-axis imu sample calibration block
// no dependencies; imported by imu_sample_calibration_top
package imucal_pkg;

	localparam int unsigned RAW_W    = 16;
	localparam int unsigned REG_W    = 48;
	localparam int unsigned ACC_OUT_W = 20;
	localparam int unsigned GYR_OUT_W = 24;
	localparam int unsigned ACC_SHIFT = 14;
	localparam int unsigned GYR_SHIFT = 19;

	// bias-removed sample, coefficient products, sums and scaled gyro
	localparam int unsigned DIFF_W  = RAW_W + 1;
	localparam int unsigned PROD_W  = DIFF_W + RAW_W;
	localparam int unsigned ASUM_W  = PROD_W + 3;
	localparam int unsigned GSCL_W  = PROD_W + 12;

	// -pi/180 in q0.16, folded with the alignment negation
	localparam logic signed [11:0] NEG_DEG2RAD = -12'sd1144;

	localparam logic [REG_W-1:0] ACCEL_BIAS_RST = 48'h0000_0000_0000;
	localparam logic [REG_W-1:0] ACCEL_ROWX_RST = 48'h0000_0000_4000;
	localparam logic [REG_W-1:0] ACCEL_ROWY_RST = 48'h0000_4000_0000;
	localparam logic [REG_W-1:0] ACCEL_ROWZ_RST = 48'h4000_0000_0000;
	localparam logic [REG_W-1:0] GYRO_BIAS_RST  = 48'h0000_0000_0000;
	localparam logic [REG_W-1:0] GYRO_SCALE_RST = 48'h0800_0800_0800;

	typedef enum logic [2:0] {
		REG_ACCEL_BIAS  = 3'd0,
		REG_ACCEL_ROWX  = 3'd1,
		REG_ACCEL_ROWY  = 3'd2,
		REG_ACCEL_ROWZ  = 3'd3,
		REG_GYRO_BIAS   = 3'd4,
		REG_GYRO_SCALE  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [RAW_W-1:0] accel_x;
		logic signed [RAW_W-1:0] accel_y;
		logic signed [RAW_W-1:0] accel_z;
		logic signed [RAW_W-1:0] gyro_x;
		logic signed [RAW_W-1:0] gyro_y;
		logic signed [RAW_W-1:0] gyro_z;
	} imu_in_t;

	typedef struct packed {
		logic signed [ACC_OUT_W-1:0] accel_out_x;
		logic signed [ACC_OUT_W-1:0] accel_out_y;
		logic signed [ACC_OUT_W-1:0] accel_out_z;
		logic signed [GYR_OUT_W-1:0] gyro_out_x;
		logic signed [GYR_OUT_W-1:0] gyro_out_y;
		logic signed [GYR_OUT_W-1:0] gyro_out_z;
	} imu_out_t;

	// round half up then saturate, accel path
	function automatic logic signed [ACC_OUT_W-1:0] acc_round_sat(
		input logic signed [ASUM_W-1:0] v
	);
		logic signed [ASUM_W-1:0] t;
		logic signed [ASUM_W-ACC_SHIFT-1:0] r;
		t = v + (ASUM_W'(1) <<< (ACC_SHIFT - 1));
		r = t[ASUM_W-1:ACC_SHIFT];
		if (!r[ASUM_W-ACC_SHIFT-1] && (|r[ASUM_W-ACC_SHIFT-2:ACC_OUT_W-1]))
			return {1'b0, {(ACC_OUT_W-1){1'b1}}};
		else if (r[ASUM_W-ACC_SHIFT-1] && !(&r[ASUM_W-ACC_SHIFT-2:ACC_OUT_W-1]))
			return {1'b1, {(ACC_OUT_W-1){1'b0}}};
		else
			return r[ACC_OUT_W-1:0];
	endfunction

	// round half up then saturate, gyro path
	function automatic logic signed [GYR_OUT_W-1:0] gyr_round_sat(
		input logic signed [GSCL_W-1:0] v
	);
		logic signed [GSCL_W-1:0] t;
		logic signed [GSCL_W-GYR_SHIFT-1:0] r;
		t = v + (GSCL_W'(1) <<< (GYR_SHIFT - 1));
		r = t[GSCL_W-1:GYR_SHIFT];
		if (!r[GSCL_W-GYR_SHIFT-1] && (|r[GSCL_W-GYR_SHIFT-2:GYR_OUT_W-1]))
			return {1'b0, {(GYR_OUT_W-1){1'b1}}};
		else if (r[GSCL_W-GYR_SHIFT-1] && !(&r[GSCL_W-GYR_SHIFT-2:GYR_OUT_W-1]))
			return {1'b1, {(GYR_OUT_W-1){1'b0}}};
		else
			return r[GYR_OUT_W-1:0];
	endfunction

endpackage

// File: sv/imu_sample_calibration_top.sv
// imu_sample_calibration_top: four-stage pipeline applying bias, matrix, scale and alignment
// depends on imucal_pkg for payload structs, register codes and rounding functions
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one raw six-axis sample per beat.
//   out channel (out_valid/out_ready/out_data): one calibrated, aligned sample per beat.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes, always ready;
//     indexes above the last register are dropped. Write only while the pipe is empty.
// Throughput: one sample per cycle while out_ready is high, set by four register stages each with one
//   multiply or add level (bias subtract, products, sums and deg-to-rad multiply,
//   round and saturate).
// Path: an accepted sample moves through the s1, s2, s3 and s4 registers before out_valid offers it.
// Stall: each stage holds while the stage after it is full and not moving; empty
//   stages keep filling, so up to four samples are held and in_ready only drops
//   once the whole pipe is full and out_ready is low.
// Reset: arst_n clears all valid bits and loads identity matrix, unit gyro scale
//   and zero biases.
module imu_sample_calibration_top
	import imucal_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  imu_in_t         in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output imu_out_t        out_data,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [REG_W-1:0] cfg_data
);

	logic [REG_W-1:0] accel_bias_q, row_x_q, row_y_q, row_z_q, gyro_bias_q, gyro_scale_q;

	logic signed [RAW_W-1:0] ab [3];
	logic signed [RAW_W-1:0] gb [3];
	logic signed [RAW_W-1:0] gs [3];
	logic signed [RAW_W-1:0] mat [3][3];

	logic signed [RAW_W-1:0] araw [3];
	logic signed [RAW_W-1:0] graw [3];

	logic                     v_s1, v_s2, v_s3, v_s4;
	logic                     rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic signed [DIFF_W-1:0] ad_s1 [3];
	logic signed [DIFF_W-1:0] gd_s1 [3];
	logic signed [PROD_W-1:0] ap_s2 [3][3];
	logic signed [PROD_W-1:0] gp_s2 [3];
	logic signed [ASUM_W-1:0] as_s3 [3];
	logic signed [GSCL_W-1:0] gm_s3 [3];
	imu_out_t                 res_s4;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_bias_q <= ACCEL_BIAS_RST;
			row_x_q      <= ACCEL_ROWX_RST;
			row_y_q      <= ACCEL_ROWY_RST;
			row_z_q      <= ACCEL_ROWZ_RST;
			gyro_bias_q  <= GYRO_BIAS_RST;
			gyro_scale_q <= GYRO_SCALE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ACCEL_BIAS: accel_bias_q <= cfg_data;
				REG_ACCEL_ROWX: row_x_q      <= cfg_data;
				REG_ACCEL_ROWY: row_y_q      <= cfg_data;
				REG_ACCEL_ROWZ: row_z_q      <= cfg_data;
				REG_GYRO_BIAS:  gyro_bias_q  <= cfg_data;
				REG_GYRO_SCALE: gyro_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ab[k]     = accel_bias_q[RAW_W*k +: RAW_W];
			gb[k]     = gyro_bias_q[RAW_W*k +: RAW_W];
			gs[k]     = gyro_scale_q[RAW_W*k +: RAW_W];
			mat[0][k] = row_x_q[RAW_W*k +: RAW_W];
			mat[1][k] = row_y_q[RAW_W*k +: RAW_W];
			mat[2][k] = row_z_q[RAW_W*k +: RAW_W];
		end
	end

	assign araw[0] = in_data.accel_x;
	assign araw[1] = in_data.accel_y;
	assign araw[2] = in_data.accel_z;
	assign graw[0] = in_data.gyro_x;
	assign graw[1] = in_data.gyro_y;
	assign graw[2] = in_data.gyro_z;

	// stage handshake
	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// s1: bias removal
	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			for (int k = 0; k < 3; k++) begin
				ad_s1[k] <= DIFF_W'(araw[k]) - DIFF_W'(ab[k]);
				gd_s1[k] <= DIFF_W'(graw[k]) - DIFF_W'(gb[k]);
			end
		end
	end

	// s2: matrix products and gyro scale
	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++)
					ap_s2[i][j] <= PROD_W'(mat[i][j] * ad_s1[j]);
				gp_s2[i] <= PROD_W'(gd_s1[i] * gs[i]);
			end
		end
	end

	// s3: row sums negated, gyro times -pi/180
	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			for (int i = 0; i < 3; i++) begin
				as_s3[i] <= -(ASUM_W'(ap_s2[i][0]) + ASUM_W'(ap_s2[i][1])
					+ ASUM_W'(ap_s2[i][2]));
				gm_s3[i] <= GSCL_W'(gp_s2[i] * NEG_DEG2RAD);
			end
		end
	end

	// s4: swap axes, round and saturate
	always_ff @(posedge clk) begin
		if (v_s3 && rdy_s4) begin
			res_s4.accel_out_x <= acc_round_sat(as_s3[1]);
			res_s4.accel_out_y <= acc_round_sat(as_s3[0]);
			res_s4.accel_out_z <= acc_round_sat(as_s3[2]);
			res_s4.gyro_out_x  <= gyr_round_sat(gm_s3[1]);
			res_s4.gyro_out_y  <= gyr_round_sat(gm_s3[0]);
			res_s4.gyro_out_z  <= gyr_round_sat(gm_s3[2]);
		end
	end

	assign out_valid = v_s4;
	assign out_data  = res_s4;

	a_drain_opens_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("in_ready low while output side drains");

	a_empty_head_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("first stage empty but input stalled");

	a_no_lost_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !rdy_s4) |=> v_s3 && v_s4)
		else $error("sample lost behind stalled output stage");

	a_fill_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted sample did not reach first stage");

endmodule

// File: tb/tb_imu_sample_calibration_top.sv
// tb_imu_sample_calibration_top: self-checking bench for the six-axis imu calibration pipe
// predicts bias, matrix, gyro scale, deg-to-rad and alignment per beat; needs imucal_pkg
// and imu_sample_calibration_top
`timescale 1ns / 100ps

import imucal_pkg::*;

localparam longint DEG2RAD_Q16 = 1144;
localparam longint ACC_HI = (longint'(1) <<< (ACC_OUT_W - 1)) - 1;
localparam longint ACC_LO = -(longint'(1) <<< (ACC_OUT_W - 1));
localparam longint GYR_HI = (longint'(1) <<< (GYR_OUT_W - 1)) - 1;
localparam longint GYR_LO = -(longint'(1) <<< (GYR_OUT_W - 1));

class calib_scoreboard;
	logic [REG_W-1:0] regs [6];
	imu_out_t expected_q [$];
	int unsigned errors;

	function new();
		regs[REG_ACCEL_BIAS] = 48'h0000_0000_0000;
		regs[REG_ACCEL_ROWX] = 48'h0000_0000_4000;
		regs[REG_ACCEL_ROWY] = 48'h0000_4000_0000;
		regs[REG_ACCEL_ROWZ] = 48'h4000_0000_0000;
		regs[REG_GYRO_BIAS]  = 48'h0000_0000_0000;
		regs[REG_GYRO_SCALE] = 48'h0800_0800_0800;
		errors = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [REG_W-1:0] val);
		case (idx)
			REG_ACCEL_BIAS, REG_ACCEL_ROWX, REG_ACCEL_ROWY, REG_ACCEL_ROWZ,
			REG_GYRO_BIAS, REG_GYRO_SCALE: regs[idx] = val;
			default: ;
		endcase
	endfunction

	function longint lane(logic [REG_W-1:0] r, int k);
		logic signed [RAW_W-1:0] e;
		e = r[RAW_W*k +: RAW_W];
		return longint'(e);
	endfunction

	// round half up, then clamp
	function longint round_sat(longint v, int sh, longint lo, longint hi);
		longint r;
		r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
		if (r > hi)
			r = hi;
		if (r < lo)
			r = lo;
		return r;
	endfunction

	function void note_sample(imu_in_t s);
		longint a [3];
		longint g [3];
		longint d [3];
		longint acc [3];
		longint gyr [3];
		imu_out_t e;
		a[0] = s.accel_x;
		a[1] = s.accel_y;
		a[2] = s.accel_z;
		g[0] = s.gyro_x;
		g[1] = s.gyro_y;
		g[2] = s.gyro_z;
		for (int j = 0; j < 3; j++)
			d[j] = a[j] - lane(regs[REG_ACCEL_BIAS], j);
		for (int i = 0; i < 3; i++) begin
			acc[i] = 0;
			for (int j = 0; j < 3; j++)
				acc[i] += lane(regs[REG_ACCEL_ROWX + i], j) * d[j];
			gyr[i] = (g[i] - lane(regs[REG_GYRO_BIAS], i)) * lane(regs[REG_GYRO_SCALE], i)
				* DEG2RAD_Q16;
		end
		// sensor to body: x' = -y, y' = -x, z' = -z
		e.accel_out_x = ACC_OUT_W'(round_sat(-acc[1], ACC_SHIFT, ACC_LO, ACC_HI));
		e.accel_out_y = ACC_OUT_W'(round_sat(-acc[0], ACC_SHIFT, ACC_LO, ACC_HI));
		e.accel_out_z = ACC_OUT_W'(round_sat(-acc[2], ACC_SHIFT, ACC_LO, ACC_HI));
		e.gyro_out_x  = GYR_OUT_W'(round_sat(-gyr[1], GYR_SHIFT, GYR_LO, GYR_HI));
		e.gyro_out_y  = GYR_OUT_W'(round_sat(-gyr[0], GYR_SHIFT, GYR_LO, GYR_HI));
		e.gyro_out_z  = GYR_OUT_W'(round_sat(-gyr[2], GYR_SHIFT, GYR_LO, GYR_HI));
		expected_q.push_back(e);
	endfunction

	function void cmp_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	function void check_result(imu_out_t got);
		imu_out_t e;
		if (expected_q.size() == 0) begin
			$display("%0t unexpected beat: expected none actual %h", $time, got);
			errors++;
			return;
		end
		e = expected_q.pop_front();
		cmp_field("accel_out_x", e.accel_out_x, got.accel_out_x);
		cmp_field("accel_out_y", e.accel_out_y, got.accel_out_y);
		cmp_field("accel_out_z", e.accel_out_z, got.accel_out_z);
		cmp_field("gyro_out_x", e.gyro_out_x, got.gyro_out_x);
		cmp_field("gyro_out_y", e.gyro_out_y, got.gyro_out_y);
		cmp_field("gyro_out_z", e.gyro_out_z, got.gyro_out_z);
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module tb_imu_sample_calibration_top;
	localparam logic [2:0] CFG_SPARE_LO = 3'd6;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;
	localparam logic [REG_W-1:0] ROW_X_UNIT = 48'h0000_0000_4000;
	localparam logic [REG_W-1:0] ROW_Y_UNIT = 48'h0000_4000_0000;
	localparam logic [REG_W-1:0] ROW_Z_UNIT = 48'h4000_0000_0000;
	localparam logic [REG_W-1:0] SCALE_UNIT = 48'h0800_0800_0800;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES  = 60;
	localparam int unsigned CYCLE_LIMIT  = 100000;
	localparam int unsigned RAND_PHASES  = 10;
	localparam int unsigned PHASE_BEATS  = 103;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	imu_in_t in_data;
	logic out_valid;
	logic out_ready;
	imu_out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [REG_W-1:0] cfg_data;

	calib_scoreboard sb;
	bit bursts_on;
	bit choke_out;
	int unsigned cycle_count;

	imu_sample_calibration_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_imu_sample_calibration_top failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (out_valid && out_ready)
				sb.check_result(out_data);
			if (in_valid && in_ready)
				sb.note_sample(in_data);
		end
	end

	// result side: random stall bursts, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (choke_out) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				choke_out = 1'b0;
				out_ready <= 1'b1;
			end else if (bursts_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic logic [RAW_W-1:0] raw_value();
		logic [RAW_W-1:0] v;
		case ($urandom_range(0, 7))
			0: v = 16'h7fff;
			1: v = 16'h8000;
			2: v = RAW_W'($urandom_range(0, 64)) - 16'd32;
			default: v = RAW_W'($urandom());
		endcase
		return v;
	endfunction

	function automatic imu_in_t random_sample();
		imu_in_t s;
		s.accel_x = raw_value();
		s.accel_y = raw_value();
		s.accel_z = raw_value();
		s.gyro_x  = raw_value();
		s.gyro_y  = raw_value();
		s.gyro_z  = raw_value();
		return s;
	endfunction

	function automatic logic [REG_W-1:0] jitter(logic [REG_W-1:0] center, int spread);
		logic [REG_W-1:0] r;
		for (int k = 0; k < 3; k++)
			r[RAW_W*k +: RAW_W] = center[RAW_W*k +: RAW_W]
				+ RAW_W'($urandom_range(0, 2 * spread)) - RAW_W'(spread);
		return r;
	endfunction

	function automatic void pick_regs(input int mode, output logic [REG_W-1:0] r [6]);
		case (mode)
			0: begin
				r[REG_ACCEL_BIAS] = jitter('0, 600);
				r[REG_ACCEL_ROWX] = jitter(ROW_X_UNIT, 2000);
				r[REG_ACCEL_ROWY] = jitter(ROW_Y_UNIT, 2000);
				r[REG_ACCEL_ROWZ] = jitter(ROW_Z_UNIT, 2000);
				r[REG_GYRO_BIAS]  = jitter('0, 300);
				r[REG_GYRO_SCALE] = jitter(SCALE_UNIT, 400);
			end
			1: begin
				r[REG_ACCEL_BIAS] = REG_W'({$urandom(), $urandom()});
				r[REG_ACCEL_ROWX] = REG_W'({$urandom(), $urandom()});
				r[REG_ACCEL_ROWY] = REG_W'({$urandom(), $urandom()});
				r[REG_ACCEL_ROWZ] = REG_W'({$urandom(), $urandom()});
				r[REG_GYRO_BIAS]  = REG_W'({$urandom(), $urandom()});
				r[REG_GYRO_SCALE] = REG_W'({$urandom(), $urandom()});
			end
			default: begin
				r[REG_ACCEL_BIAS] = REG_W'({$urandom(), $urandom()});
				r[REG_ACCEL_ROWX] = jitter(ROW_X_UNIT, 16384);
				r[REG_ACCEL_ROWY] = jitter(ROW_Y_UNIT, 16384);
				r[REG_ACCEL_ROWZ] = jitter(ROW_Z_UNIT, 16384);
				r[REG_GYRO_BIAS]  = REG_W'({$urandom(), $urandom()});
				r[REG_GYRO_SCALE] = jitter(SCALE_UNIT, 8192);
			end
		endcase
	endfunction

	// writes every register; the spare indexes get junk that must be dropped
	task automatic load_regs(input logic [REG_W-1:0] vals [6]);
		logic [2:0] idx_q [$];
		idx_q = '{REG_ACCEL_BIAS, REG_ACCEL_ROWX, CFG_SPARE_LO, REG_ACCEL_ROWY,
			REG_ACCEL_ROWZ, REG_GYRO_BIAS, REG_GYRO_SCALE, CFG_SPARE_HI};
		foreach (idx_q[i]) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx_q[i];
			if (idx_q[i] > REG_GYRO_SCALE)
				cfg_data <= REG_W'({$urandom(), $urandom()});
			else
				cfg_data <= vals[idx_q[i]];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic drive_samples(input imu_in_t batch [$]);
		foreach (batch[i]) begin
			if (bursts_on && $urandom_range(0, 4) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			in_valid <= 1'b1;
			in_data  <= batch[i];
			do @(posedge clk); while (!in_ready);
		end
		in_valid <= 1'b0;
	endtask

	task automatic settle();
		do @(posedge clk); while (sb.pending() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// extremes, bit patterns and gyro half-way rounding at unit scale
	task automatic run_directed();
		imu_in_t batch [$];
		batch.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
		batch.push_back('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
		batch.push_back('{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
		batch.push_back('{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
		batch.push_back('{16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa});
		batch.push_back('{16'h0001, 16'hffff, 16'h0002, 16'hfffe, 16'h0003, 16'hfffd});
		batch.push_back('{16'h0123, 16'hfedc, 16'h1000, 16'h0010, 16'hfff0, 16'h0030});
		batch.push_back('{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff});
		drive_samples(batch);
	endtask

	initial begin
		logic [REG_W-1:0] regset [6];
		imu_in_t batch [$];
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycle_count = 0;
		bursts_on = 1'b1;
		choke_out = 1'b0;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		run_directed();
		settle();
		foreach (regset[k])
			regset[k] = 48'h8000_8000_8000;
		load_regs(regset);
		run_directed();
		settle();
		foreach (regset[k])
			regset[k] = 48'h7fff_7fff_7fff;
		load_regs(regset);
		run_directed();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			settle();
			pick_regs(ph % 3, regset);
			load_regs(regset);
			if (ph == 3)
				choke_out = 1'b1;
			if (ph == RAND_PHASES - 2)
				bursts_on = 1'b0;
			batch.delete();
			repeat (PHASE_BEATS)
				batch.push_back(random_sample());
			drive_samples(batch);
		end

		settle();
		if (sb.errors == 0)
			$display("tb_imu_sample_calibration_top passed");
		else
			$display("tb_imu_sample_calibration_top failed");
		$finish;
	end
endmodule
